// ----- src/osm_pkg.sv -----
//------------------------------------------------------------------------------
// osm_pkg
// Shared types and constants of the one-wire slot master.
//------------------------------------------------------------------------------
`default_nettype none

package osm_pkg;

    localparam int BUFFER_BYTES    = 16;
    localparam int BUF_AW          = $clog2(BUFFER_BYTES);
    localparam int BIT_SHIFT       = 3;
    localparam int POS_W           = $clog2(BUFFER_BYTES * 8 + 2);
    localparam int SLOT_W          = 5;
    localparam int PRESENCE_SLOT   = 9;
    localparam int LAST_RESET_SLOT = 16;

    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 16;

    typedef enum logic [1:0] {
        OP_WRITE_BUF = 2'd0,
        OP_READ_BUF  = 2'd1,
        OP_START     = 2'd2,
        OP_TICK      = 2'd3
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [3:0] index;
        logic [7:0] data_byte;
        logic [4:0] write_bytes;
        logic [4:0] read_bytes;
        logic       line_level;
    } item_t;

    // Buffer access for one item.
    typedef struct packed {
        logic              wr_byte;
        logic              wr_bit;
        logic              rd;
        logic [BUF_AW-1:0] addr;
        logic [2:0]        bit_sel;
        logic [7:0]        wdata;
        logic              wbit;
    } buf_req_t;

    // Result flags; the buffer byte is merged in at the output stage.
    typedef struct packed {
        logic       drive_low;
        logic       release_fixed;
        logic       release_from_buf;
        logic [2:0] bit_sel;
        logic       high_after;
        logic       rd_valid;
        logic       busy;
        logic       present;
    } res_t;

endpackage

`default_nettype wire

// ----- src/osm_in_stage.sv -----
//------------------------------------------------------------------------------
// osm_in_stage
// Input register of the slot master with its stream handshake.
//------------------------------------------------------------------------------
`default_nettype none

module osm_in_stage
    import osm_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    input  wire logic [IN_DATA_W-1:0] s_axis_tdata,
    input  wire logic [1:0]           s_axis_tuser,
    input  wire logic                 out_free,
    output item_t                     item,
    output logic                      item_valid
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;
    logic  take;
    logic  fire;

    assign fire          = valid_reg && out_free;
    assign s_axis_tready = !valid_reg || out_free;
    assign take          = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (fire)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg.op          <= op_t'(s_axis_tuser);
            item_reg.index       <= s_axis_tdata[3:0];
            item_reg.data_byte   <= s_axis_tdata[11:4];
            item_reg.write_bytes <= s_axis_tdata[16:12];
            item_reg.read_bytes  <= s_axis_tdata[21:17];
            item_reg.line_level  <= s_axis_tdata[22];
        end
    end

    assign item       = item_reg;
    assign item_valid = valid_reg;

endmodule

`default_nettype wire

// ----- src/osm_slot_ctrl.sv -----
//------------------------------------------------------------------------------
// osm_slot_ctrl
// Transaction state of the slot master: reset slots, write and read phases.
//------------------------------------------------------------------------------
`default_nettype none

module osm_slot_ctrl
    import osm_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire item_t item,
    input  wire logic  fire,
    output buf_req_t   buf_req,
    output res_t       res
);

    logic [SLOT_W-1:0] reset_slot_reg, reset_slot_next;
    logic              write_active_reg, write_active_next;
    logic              read_active_reg, read_active_next;
    logic              sample_pending_reg, sample_pending_next;
    logic [POS_W-1:0]  send_pos_reg, send_pos_next;
    logic [POS_W-1:0]  recv_pos_reg, recv_pos_next;
    logic [POS_W-1:0]  send_total_reg, send_total_next;
    logic [POS_W-1:0]  recv_total_reg, recv_total_next;
    logic              present_reg, present_next;

    logic [POS_W-1:0]  wb_clamped;
    logic [POS_W-1:0]  rb_clamped;
    logic [POS_W-1:0]  send_byte;
    logic [POS_W-1:0]  recv_byte;
    logic              send_in_buf;
    logic              recv_in_buf;

    always_comb
    begin
        wb_clamped = (32'(item.write_bytes) > BUFFER_BYTES) ? POS_W'(BUFFER_BYTES)
                                                            : POS_W'(item.write_bytes);
        rb_clamped = (32'(item.read_bytes) > BUFFER_BYTES) ? POS_W'(BUFFER_BYTES)
                                                           : POS_W'(item.read_bytes);
        send_byte   = send_pos_reg >> BIT_SHIFT;
        recv_byte   = recv_pos_reg >> BIT_SHIFT;
        send_in_buf = 32'(send_byte) < BUFFER_BYTES;
        recv_in_buf = 32'(recv_byte) < BUFFER_BYTES;
    end

    always_comb
    begin
        reset_slot_next     = reset_slot_reg;
        write_active_next   = write_active_reg;
        read_active_next    = read_active_reg;
        sample_pending_next = sample_pending_reg;
        send_pos_next       = send_pos_reg;
        recv_pos_next       = recv_pos_reg;
        send_total_next     = send_total_reg;
        recv_total_next     = recv_total_reg;
        present_next        = present_reg;

        buf_req             = '0;
        buf_req.addr        = BUF_AW'(item.index);
        buf_req.wdata       = item.data_byte;
        buf_req.wbit        = item.line_level;

        res                 = '0;

        case (item.op)
            OP_WRITE_BUF:
            begin
                buf_req.wr_byte = fire && (32'(item.index) < BUFFER_BYTES);
            end
            OP_READ_BUF:
            begin
                buf_req.rd   = fire && (32'(item.index) < BUFFER_BYTES);
                res.rd_valid = 32'(item.index) < BUFFER_BYTES;
            end
            OP_START:
            begin
                reset_slot_next   = SLOT_W'(1);
                send_pos_next     = '0;
                send_total_next   = POS_W'(wb_clamped << BIT_SHIFT);
                write_active_next = wb_clamped != '0;
                recv_pos_next     = '0;
                recv_total_next   = POS_W'(rb_clamped << BIT_SHIFT);
                read_active_next  = rb_clamped != '0;
            end
            OP_TICK:
            begin
                if (reset_slot_reg != '0)
                begin
                    if (32'(reset_slot_reg) < PRESENCE_SLOT)
                    begin
                        res.drive_low   = 1'b1;
                        reset_slot_next = reset_slot_reg + SLOT_W'(1);
                    end
                    else
                    begin
                        res.high_after = 1'b1;
                        if (32'(reset_slot_reg) == PRESENCE_SLOT)
                        begin
                            present_next = !item.line_level;
                            // No presence pulse: the whole transaction is dropped.
                            if (item.line_level)
                            begin
                                reset_slot_next     = '0;
                                sample_pending_next = 1'b0;
                                write_active_next   = 1'b0;
                                read_active_next    = 1'b0;
                            end
                            else
                            begin
                                reset_slot_next = reset_slot_reg + SLOT_W'(1);
                            end
                        end
                        else if (32'(reset_slot_reg) >= LAST_RESET_SLOT)
                        begin
                            reset_slot_next = '0;
                        end
                        else
                        begin
                            reset_slot_next = reset_slot_reg + SLOT_W'(1);
                        end
                    end
                end
                else
                begin
                    res.high_after = 1'b1;
                    if (write_active_reg)
                    begin
                        res.drive_low        = 1'b1;
                        res.release_from_buf = send_in_buf;
                        res.bit_sel          = send_pos_reg[2:0];
                        buf_req.rd           = fire && send_in_buf;
                        buf_req.addr         = BUF_AW'(send_byte);
                        send_pos_next        = send_pos_reg + POS_W'(1);
                        write_active_next    = send_pos_next < send_total_reg;
                    end
                    else
                    begin
                        // The sample of the previous read slot is stored first.
                        if (sample_pending_reg)
                        begin
                            buf_req.wr_bit      = fire && recv_in_buf;
                            buf_req.addr        = BUF_AW'(recv_byte);
                            buf_req.bit_sel     = recv_pos_reg[2:0];
                            recv_pos_next       = recv_pos_reg + POS_W'(1);
                            read_active_next    = recv_pos_next < recv_total_reg;
                            sample_pending_next = read_active_next;
                        end
                        if (read_active_next)
                        begin
                            res.drive_low       = 1'b1;
                            res.release_fixed   = 1'b1;
                            sample_pending_next = 1'b1;
                        end
                    end
                end
            end
            default:
            begin
                res = '0;
            end
        endcase

        res.busy    = (reset_slot_next != '0) || write_active_next || read_active_next;
        res.present = present_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reset_slot_reg     <= '0;
            write_active_reg   <= 1'b0;
            read_active_reg    <= 1'b0;
            sample_pending_reg <= 1'b0;
            send_pos_reg       <= '0;
            recv_pos_reg       <= '0;
            send_total_reg     <= '0;
            recv_total_reg     <= '0;
            present_reg        <= 1'b0;
        end
        else if (fire)
        begin
            reset_slot_reg     <= reset_slot_next;
            write_active_reg   <= write_active_next;
            read_active_reg    <= read_active_next;
            sample_pending_reg <= sample_pending_next;
            send_pos_reg       <= send_pos_next;
            recv_pos_reg       <= recv_pos_next;
            send_total_reg     <= send_total_next;
            recv_total_reg     <= recv_total_next;
            present_reg        <= present_next;
        end
    end

endmodule

`default_nettype wire

// ----- src/osm_buf.sv -----
//------------------------------------------------------------------------------
// osm_buf
// Byte buffer with byte and single-bit writes and a registered read port.
//------------------------------------------------------------------------------
`default_nettype none

module osm_buf
    import osm_pkg::*;
(
    input  wire logic     clk,
    input  wire buf_req_t req,
    output logic [7:0]    rdata
);

    logic [7:0] mem [BUFFER_BYTES];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_byte)
        begin
            mem[req.addr] <= req.wdata;
        end
        if (req.wr_bit)
        begin
            mem[req.addr][req.bit_sel] <= req.wbit;
        end
        if (req.rd)
        begin
            rdata_reg <= mem[req.addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- src/osm_out_stage.sv -----
//------------------------------------------------------------------------------
// osm_out_stage
// Result register of the slot master; merges the buffer byte into the result.
//------------------------------------------------------------------------------
`default_nettype none

module osm_out_stage
    import osm_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  fire,
    input  wire res_t                  res,
    input  wire logic [7:0]            rdata,
    output logic                       out_free,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0]      m_axis_tdata
);

    logic valid_reg;
    logic valid_next;
    res_t res_reg;
    logic release_early;
    logic [7:0] read_byte;

    assign out_free = !valid_reg || m_axis_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (fire)
        begin
            valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            res_reg <= res;
        end
    end

    // The buffer read data stays put while this stage holds its result.
    always_comb
    begin
        release_early = res_reg.release_fixed
                        || (res_reg.release_from_buf && rdata[res_reg.bit_sel]);
        read_byte     = res_reg.rd_valid ? rdata : 8'h00;
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = {3'b000, res_reg.present, res_reg.busy, read_byte,
                            res_reg.high_after, release_early, res_reg.drive_low};

endmodule

`default_nettype wire

// ----- src/one_wire_slot_master_top.sv -----
//------------------------------------------------------------------------------
// one_wire_slot_master_top
// One-wire bus master that plans the pin actions one time slot at a time.
//------------------------------------------------------------------------------
// The slave stream carries commands: tuser selects buffer write, buffer read,
// transaction start or slot tick, and tdata carries the operands. Every
// accepted transaction returns exactly one result transaction on the master
// stream with the pin actions for the next slot, a buffer byte, busy and
// presence. A transaction opens with sixteen reset slots (eight drive low,
// the ninth samples presence), then sends buffer bits LSB first, then runs
// read slots whose samples land in the buffer from bit 0.
// One command is taken per cycle while the receiver takes results; the input
// register, the state update with its single buffer access, and the result
// register form a two-stage path. Reset clears the transaction state and
// both stages; buffer contents are undefined until written. When the
// receiver stalls, the result register holds and the input register, if
// empty, still takes one more command before tready drops.
//------------------------------------------------------------------------------
`default_nettype none

module one_wire_slot_master_top
    import osm_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // [3:0] index, [11:4] data_byte, [16:12] write_bytes, [21:17] read_bytes,
    // [22] line_level, [23] zero
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
    // [1:0] op
    input  wire logic [1:0]            s_axis_tuser,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // [0] slot_drive_low, [1] slot_release_early, [2] slot_drive_high_after,
    // [10:3] read_byte, [11] busy_res, [12] device_present, [15:13] zero
    output logic [OUT_DATA_W-1:0]      m_axis_tdata
);

    item_t      item;
    logic       item_valid;
    logic       out_free;
    logic       fire;
    buf_req_t   buf_req;
    res_t       res;
    logic [7:0] rdata;

    assign fire = item_valid && out_free;

    osm_in_stage u_in (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .out_free      (out_free),
        .item          (item),
        .item_valid    (item_valid)
    );

    osm_slot_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .item    (item),
        .fire    (fire),
        .buf_req (buf_req),
        .res     (res)
    );

    osm_buf u_buf (
        .clk   (clk),
        .req   (buf_req),
        .rdata (rdata)
    );

    osm_out_stage u_out (
        .clk           (clk),
        .rst_n         (rst_n),
        .fire          (fire),
        .res           (res),
        .rdata         (rdata),
        .out_free      (out_free),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

`default_nettype wire

// ----- src/osm_checker.sv -----
//------------------------------------------------------------------------------
// osm_checker
// Port-level checks of the slot master, bound to the top level.
//------------------------------------------------------------------------------
`default_nettype none

module osm_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [15:0] m_axis_tdata
);

    // A stalled result transaction keeps its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // No result can be ready in the first cycle after reset.
    assert property (@(posedge clk) disable iff (!rst_n)
        $past(!rst_n) |-> !m_axis_tvalid)
        else $error("result valid right after reset");

    // An early release only ever follows a low drive in the same slot.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[1] |-> m_axis_tdata[0])
        else $error("release without drive low");

    // A buffer byte is returned only by a buffer read, which plans no slot.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tdata[10:3] != 8'h00) |-> (m_axis_tdata[2:0] == 3'b000))
        else $error("buffer byte with pin actions");

endmodule

bind one_wire_slot_master_top osm_checker u_osm_checker (.*);

`default_nettype wire

// ----- bench/tb_one_wire_slot_master_top.sv -----
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// tb_one_wire_slot_master_top
// Self-checking bench for the one-wire slot master.
//------------------------------------------------------------------------------
// Commands go in on the slave stream and slot plans come back on the master
// stream. A shadow copy of the slot sequencer predicts one plan per accepted
// command, and each returned plan is checked field by field against the
// oldest prediction. The buffer is filled first, so every transaction sends
// and receives defined bytes. Directed tests cover the buffer ports, an idle
// tick, an absent device and a restart. A saturated transaction runs under a
// long receiver hold-off. Random transactions follow, mostly well formed with
// a device present, mixed with buffer traffic, aborts and stray ticks.
//------------------------------------------------------------------------------

module tb_one_wire_slot_master_top;
    import osm_pkg::*;

    localparam int CLK_HALF        = 6;
    localparam int RESET_CYCLES    = 9;
    localparam int HOLD_OFF_CYCLES = 120;
    localparam int SETTLE_CYCLES   = 8;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int REPORT_LIMIT    = 10;

    // Packed in the order of the result stream, most significant field first.
    typedef struct packed {
        logic [2:0] pad;
        logic       present;
        logic       busy;
        logic [7:0] rd_byte;
        logic       high_after;
        logic       release_early;
        logic       drive_low;
    } slot_plan_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic [1:0]            s_axis_tuser = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    // Shadow of the slot sequencer.
    logic [4:0] reset_slot_sh;
    logic       sending;
    logic       receiving;
    logic       sample_due;
    logic [7:0] tx_bit;
    logic [7:0] rx_bit;
    logic [7:0] tx_bits;
    logic [7:0] rx_bits;
    logic       presence_seen;
    logic [7:0] shadow_buf [BUFFER_BYTES];

    slot_plan_t pending_slot_plans[$];
    slot_plan_t want_plan;
    slot_plan_t got_plan;
    string      diff_names;

    int  mismatches = 0;
    int  items_sent = 0;
    int  cycles = 0;
    int  stalls_asked = 0;
    int  stalls_served = 0;
    bit  quiet_stretch = 1'b0;

    one_wire_slot_master_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        forever #CLK_HALF clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic slot_plan_t plan_slot(input op_t op, input logic [3:0] idx,
                                             input logic [7:0] dbyte,
                                             input logic [4:0] wbytes,
                                             input logic [4:0] rbytes,
                                             input logic level);
        slot_plan_t p;
        logic [4:0] wb;
        logic [4:0] rb;
        logic [7:0] cur;
        p = '0;
        case (op)
            OP_WRITE_BUF: shadow_buf[idx] = dbyte;
            OP_READ_BUF:  p.rd_byte = shadow_buf[idx];
            OP_START:
            begin
                wb = (wbytes > BUFFER_BYTES) ? 5'(BUFFER_BYTES) : wbytes;
                rb = (rbytes > BUFFER_BYTES) ? 5'(BUFFER_BYTES) : rbytes;
                reset_slot_sh = 5'd1;
                tx_bit = '0;
                tx_bits = {wb, 3'b000};
                sending = (wb != 0);
                rx_bit = '0;
                rx_bits = {rb, 3'b000};
                receiving = (rb != 0);
            end
            default:
            begin
                p.high_after = 1'b1;
                if (reset_slot_sh != 0)
                begin
                    if (reset_slot_sh < PRESENCE_SLOT)
                    begin
                        p.drive_low = 1'b1;
                        p.high_after = 1'b0;
                        reset_slot_sh++;
                    end
                    else if (reset_slot_sh == PRESENCE_SLOT)
                    begin
                        // A low line during the presence slot means a device answered.
                        presence_seen = !level;
                        if (!presence_seen)
                        begin
                            reset_slot_sh = '0;
                            sample_due = 1'b0;
                            sending = 1'b0;
                            receiving = 1'b0;
                        end
                        else
                            reset_slot_sh++;
                    end
                    else if (reset_slot_sh >= LAST_RESET_SLOT)
                        reset_slot_sh = '0;
                    else
                        reset_slot_sh++;
                end
                else if (sending)
                begin
                    cur = shadow_buf[tx_bit[6:3]];
                    p.drive_low = 1'b1;
                    p.release_early = cur[tx_bit[2:0]];
                    tx_bit++;
                    sending = (tx_bit < tx_bits);
                end
                else
                begin
                    // The level of a read slot arrives with the tick after it.
                    if (sample_due)
                    begin
                        shadow_buf[rx_bit[6:3]][rx_bit[2:0]] = level;
                        rx_bit++;
                        receiving = (rx_bit < rx_bits);
                        sample_due = receiving;
                    end
                    if (receiving)
                    begin
                        p.drive_low = 1'b1;
                        p.release_early = 1'b1;
                        sample_due = 1'b1;
                    end
                end
            end
        endcase
        p.busy = (reset_slot_sh != 0) || sending || receiving;
        p.present = presence_seen;
        return p;
    endfunction

    function automatic string plan_text(input slot_plan_t p);
        return $sformatf("low=%b rel=%b high=%b byte=%02h busy=%b pres=%b pad=%b",
                         p.drive_low, p.release_early, p.high_after, p.rd_byte,
                         p.busy, p.present, p.pad);
    endfunction

    function automatic string field_diffs(input slot_plan_t want, input slot_plan_t got);
        string s = "";
        if (got.drive_low !== want.drive_low)         s = {s, " slot_drive_low"};
        if (got.release_early !== want.release_early) s = {s, " slot_release_early"};
        if (got.high_after !== want.high_after)       s = {s, " slot_drive_high_after"};
        if (got.rd_byte !== want.rd_byte)             s = {s, " read_byte"};
        if (got.busy !== want.busy)                   s = {s, " busy_res"};
        if (got.present !== want.present)             s = {s, " device_present"};
        if (got.pad !== want.pad)                     s = {s, " padding"};
        return s;
    endfunction

    // Result checker.
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got_plan = m_axis_tdata;
            if (pending_slot_plans.size() == 0)
            begin
                if (mismatches < REPORT_LIMIT)
                    $display("cycle %0d: result with nothing expected: %s",
                             cycles, plan_text(got_plan));
                mismatches++;
            end
            else
            begin
                want_plan = pending_slot_plans.pop_front();
                diff_names = field_diffs(want_plan, got_plan);
                if (diff_names != "")
                begin
                    if (mismatches < REPORT_LIMIT)
                        $display("cycle %0d: mismatch in%s\n  expected %s\n  actual   %s",
                                 cycles, diff_names, plan_text(want_plan),
                                 plan_text(got_plan));
                    mismatches++;
                end
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off whenever a test asks for one.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (stalls_served != stalls_asked)
            begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                stalls_served++;
            end
            m_axis_tready <= quiet_stretch || ($urandom_range(99) >= 12);
        end
    end

    task automatic send_item(input op_t op, input logic [3:0] idx, input logic [7:0] dbyte,
                             input logic [4:0] wbytes, input logic [4:0] rbytes,
                             input logic level);
        // An idle gap before about one transaction in eight.
        if (!quiet_stretch && $urandom_range(99) < 12)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {1'b0, level, rbytes, wbytes, dbyte, idx};
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        pending_slot_plans.push_back(plan_slot(op, idx, dbyte, wbytes, rbytes, level));
        items_sent++;
    endtask

    task automatic send_tick(input logic level);
        send_item(OP_TICK, $urandom, $urandom, $urandom, $urandom, level);
    endtask

    task automatic send_start(input logic [4:0] wbytes, input logic [4:0] rbytes);
        send_item(OP_START, $urandom, $urandom, wbytes, rbytes, $urandom);
    endtask

    // The sender stops offering until every predicted plan has come back.
    task automatic wait_results_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_slot_plans.size() != 0) @(posedge clk);
    endtask

    // Presence is mostly answered so that transactions get past the reset.
    function automatic logic pick_level();
        if (reset_slot_sh == PRESENCE_SLOT)
            return ($urandom_range(99) < 85) ? 1'b0 : 1'b1;
        return 1'($urandom_range(1));
    endfunction

    function automatic logic [4:0] pick_count();
        int r;
        r = $urandom_range(99);
        if (r < 85)
            return 5'($urandom_range(0, 2));
        if (r < 97)
            return 5'($urandom_range(3, 6));
        return 5'($urandom_range(16, 31));
    endfunction

    task automatic test_buffer_access();
        int i;
        send_tick(1'b1);
        for (i = 0; i < BUFFER_BYTES; i++)
        begin
            case (i)
                0:       send_item(OP_WRITE_BUF, 4'(i), 8'h00, $urandom, $urandom, $urandom);
                1:       send_item(OP_WRITE_BUF, 4'(i), 8'hFF, $urandom, $urandom, $urandom);
                default: send_item(OP_WRITE_BUF, 4'(i), $urandom, $urandom, $urandom, $urandom);
            endcase
        end
        send_item(OP_READ_BUF, 4'd0, $urandom, $urandom, $urandom, $urandom);
        send_item(OP_READ_BUF, 4'd15, $urandom, $urandom, $urandom, $urandom);
        send_item(OP_READ_BUF, 4'd1, $urandom, $urandom, $urandom, $urandom);
    endtask

    task automatic test_absent_device();
        int i;
        send_start(5'd2, 5'd1);
        for (i = 0; i < 3; i++)
            send_tick($urandom);
        // Restart while the reset is still running.
        send_start(5'd1, 5'd1);
        for (i = 0; i < PRESENCE_SLOT - 1; i++)
            send_tick($urandom);
        send_tick(1'b1);
        send_tick(1'b0);
    endtask

    task automatic test_saturated_under_hold_off();
        stalls_asked++;
        send_start(5'd31, 5'd17);
        while ((reset_slot_sh != 0) || sending || receiving)
            send_tick((reset_slot_sh == PRESENCE_SLOT) ? 1'b0 : 1'($urandom_range(1)));
        send_item(OP_READ_BUF, 4'd15, $urandom, $urandom, $urandom, $urandom);
        wait_results_drained();
    endtask

    task automatic run_random_traffic(input int budget);
        int stop;
        int r;
        stop = items_sent + budget;
        while (items_sent < stop)
        begin
            r = $urandom_range(99);
            if (r < 70)
            begin
                send_start(pick_count(), pick_count());
                while ((reset_slot_sh != 0) || sending || receiving)
                begin
                    r = $urandom_range(99);
                    if (r < 3)
                        break;
                    else if (r < 8)
                        send_item($urandom_range(1) ? OP_WRITE_BUF : OP_READ_BUF,
                                  $urandom, $urandom, $urandom, $urandom, $urandom);
                    else
                        send_tick(pick_level());
                end
            end
            else if (r < 85)
                send_item($urandom_range(1) ? OP_WRITE_BUF : OP_READ_BUF,
                          $urandom, $urandom, $urandom, $urandom, $urandom);
            else if (r < 95)
                send_tick(pick_level());
            else
                send_start($urandom, $urandom);
        end
    endtask

    task automatic test_quiet_stretch();
        quiet_stretch = 1'b1;
        run_random_traffic(150);
        wait_results_drained();
        quiet_stretch = 1'b0;
    endtask

    initial
    begin
        reset_slot_sh = '0;
        sending = 1'b0;
        receiving = 1'b0;
        sample_due = 1'b0;
        tx_bit = '0;
        rx_bit = '0;
        tx_bits = '0;
        rx_bits = '0;
        presence_seen = 1'b0;
        foreach (shadow_buf[i])
            shadow_buf[i] = '0;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_buffer_access();
        test_absent_device();
        wait_results_drained();
        test_saturated_under_hold_off();
        test_quiet_stretch();
        run_random_traffic(450);

        wait_results_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending_slot_plans.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
